>>> rtl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

	// Busy map storage: pages per memory word
	localparam int WORD_BITS = 8;
	localparam int WORD_LOG  = 3;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int RSV_W  = 13;
	localparam logic REG_RESERVED = 1'b0;

	// Request codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_DOUBLE  = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PASS_CLEAR,
		PASS_RECOUNT,
		PASS_SCAN,
		PASS_CHECK,
		PASS_MARK
	} pass_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_RECOUNT,
		S_SCAN,
		S_CHECK,
		S_MARK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic        action;
		logic [11:0] first_page;
		logic [12:0] page_count;
		logic [12:0] align_pages;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] start_page;
		logic [12:0] allocated_count;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;
		logic    go;
		pass_t   kind;
		logic    respond;
		status_t status;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic bad;
		logic nomem;
		logic is_free;
		logic pass_done;
		logic found;
		logic dbl;
	} sts_t;

endpackage

>>> rtl/page_bitmap_allocator_top.sv
// Top level of the page bitmap allocator.
// A request is taken when start is high and busy is low; its result appears on result for
// one cycle with done high and cannot be held off. The busy map is kept in a memory of
// 8-page words and a valid request walks it one word per cycle through the memory's single
// read port: an allocate runs a first-fit search over the map and then marks the words of
// the run it finds (the search ends early when a fit is found); a free checks the words
// the run touches, then clears them. After reset the block clears the map, and after a
// write of reserved_pages it recounts the map; busy stays high during both.
module page_bitmap_allocator_top
	import pba_pkg::*;
#(
	parameter int NUM_PAGES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output res_t              result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cmd_t             cmd;
	sts_t             sts;
	logic             cfg_we;
	logic [RSV_W-1:0] reserved;

	// Register write decode
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_RESERVED);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RESERVED) ? APB_DW'(reserved) : '0;

	pba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_we(cfg_we),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	pba_dp #(
		.NUM_PAGES(NUM_PAGES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg_we  (cfg_we),
		.cfg_data(pwdata[RSV_W-1:0]),
		.cmd     (cmd),
		.sts     (sts),
		.reserved(reserved),
		.done    (done),
		.result  (result)
	);

endmodule

>>> rtl/pba_ram.sv
// Generic simple dual-port RAM with registered read.
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/pba_ctrl.sv
// Control state machine for the page bitmap allocator.
module pba_ctrl
	import pba_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic cfg_we,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t  state_q, state_nx;
	status_t status_q, status_nx;
	logic    pend_q;

	// State, held status and pending recount
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			status_q <= ST_OK;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			status_q <= status_nx;
			if (cfg_we) begin
				pend_q <= 1'b1;
			end else if (cmd.go && cmd.kind == PASS_RECOUNT) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_nx    = state_q;
		status_nx   = status_q;
		cmd.load    = 1'b0;
		cmd.go      = 1'b0;
		cmd.kind    = PASS_CLEAR;
		cmd.respond = 1'b0;
		cmd.status  = status_q;
		unique case (state_q)
			S_INIT: begin
				cmd.go   = 1'b1;
				cmd.kind = PASS_CLEAR;
				state_nx = S_CLEAR;
			end
			S_CLEAR: begin
				if (sts.pass_done) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pend_q) begin
					cmd.go   = 1'b1;
					cmd.kind = PASS_RECOUNT;
					state_nx = S_RECOUNT;
				end else if (start) begin
					cmd.load = 1'b1;
					state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.bad) begin
					status_nx = ST_INVALID;
					state_nx  = S_RESP;
				end else if (sts.nomem) begin
					status_nx = ST_NOMEM;
					state_nx  = S_RESP;
				end else if (sts.is_free) begin
					cmd.go   = 1'b1;
					cmd.kind = PASS_CHECK;
					state_nx = S_CHECK;
				end else begin
					cmd.go   = 1'b1;
					cmd.kind = PASS_SCAN;
					state_nx = S_SCAN;
				end
			end
			S_RECOUNT: begin
				if (sts.pass_done) begin
					state_nx = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.pass_done) begin
					if (sts.found) begin
						cmd.go   = 1'b1;
						cmd.kind = PASS_MARK;
						state_nx = S_MARK;
					end else begin
						status_nx = ST_NOMEM;
						state_nx  = S_RESP;
					end
				end
			end
			S_CHECK: begin
				if (sts.pass_done) begin
					if (sts.dbl) begin
						status_nx = ST_DOUBLE;
						state_nx  = S_RESP;
					end else begin
						cmd.go   = 1'b1;
						cmd.kind = PASS_MARK;
						state_nx = S_MARK;
					end
				end
			end
			S_MARK: begin
				if (sts.pass_done) begin
					status_nx = ST_OK;
					state_nx  = S_RESP;
				end
			end
			S_RESP: begin
				cmd.respond = 1'b1;
				state_nx    = S_IDLE;
			end
			default: begin
				state_nx = S_INIT;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE) || pend_q;

endmodule

>>> rtl/pba_dp.sv
// Datapath: busy map memory, word pass engine, search, check, mark and count.
module pba_dp
	import pba_pkg::*;
#(
	parameter int NUM_PAGES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             req,
	input  logic             cfg_we,
	input  logic [RSV_W-1:0] cfg_data,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [RSV_W-1:0] reserved,
	output logic             done,
	output res_t             result
);

	localparam int DEPTH = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int PGW   = AW + WORD_LOG;
	localparam int XW    = ((PGW > 14) ? PGW : 14) + 1;
	localparam int CW    = $clog2(NUM_PAGES + 1);
	localparam logic [XW-1:0] N_X = XW'(NUM_PAGES);

	req_t             req_q;
	logic [RSV_W-1:0] reserved_q;
	logic [CW-1:0]    total_q;
	res_t             res_q;
	logic             done_q;

	// Pass engine
	pass_t         kind_q;
	logic          iss_q;
	logic [AW-1:0] wa_q, hiw_q;
	logic          vld_s1, last_s1;
	logic [AW-1:0] addr_s1;

	// Search state
	logic          cv_q, found_q, dbl_q;
	logic [XW-1:0] cand_q, end_q;

	logic [XW-1:0] bound, cnt_x, first_x, align_x, amask, lo_pg, hi_pg;
	logic [XW-1:0] mlo_pg, mhi_pg;
	logic [AW-1:0] lo_w, hi_w;
	logic          is_free, a_bad, f_bad, a_nomem, pass_done, scan_upd;
	logic [WORD_BITS-1:0] rdata, wdata, rng_m, cnt_m;
	logic          we;
	logic          cv_c, f_c, dbl_c;
	logic [XW-1:0] c_c, e_c;
	logic [WORD_LOG:0] pop_c;
	logic [XW-1:0] sum_x;

	// Request, register and decoded bounds
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (cfg_we) begin
			reserved_q <= cfg_data;
		end
	end

	assign reserved = reserved_q;
	assign is_free  = (req_q.action == ACT_FREE);
	assign bound    = (XW'(reserved_q) > N_X) ? N_X : XW'(reserved_q);
	assign cnt_x    = XW'(req_q.page_count);
	assign first_x  = XW'(req_q.first_page);
	assign align_x  = XW'(req_q.align_pages);
	assign amask    = align_x - XW'(1);

	// Request checks
	assign a_bad   = (cnt_x == '0) || (align_x == '0) || ((align_x & amask) != '0);
	assign a_nomem = cnt_x > N_X;
	assign f_bad   = (cnt_x == '0) || (first_x < bound) || (first_x + cnt_x > N_X);

	// Page range of a check or mark pass
	assign lo_pg = is_free ? first_x : cand_q;
	assign hi_pg = is_free ? (first_x + cnt_x - XW'(1)) : end_q;

	// Word range at pass launch; an allocate takes the run just found by the scan
	assign mlo_pg = is_free ? lo_pg : c_c;
	assign mhi_pg = is_free ? hi_pg : e_c;
	assign lo_w   = mlo_pg[PGW-1:WORD_LOG];
	assign hi_w   = mhi_pg[PGW-1:WORD_LOG];

	// Word sweep: one read issued per cycle, data handled in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= PASS_CLEAR;
			iss_q   <= 1'b0;
			wa_q    <= '0;
			hiw_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			addr_s1 <= '0;
		end else if (cmd.go) begin
			kind_q <= cmd.kind;
			iss_q  <= 1'b1;
			vld_s1 <= 1'b0;
			if (cmd.kind == PASS_CHECK || cmd.kind == PASS_MARK) begin
				wa_q  <= lo_w;
				hiw_q <= hi_w;
			end else begin
				wa_q  <= '0;
				hiw_q <= AW'(DEPTH - 1);
			end
		end else if (pass_done) begin
			iss_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1  <= iss_q;
			addr_s1 <= wa_q;
			last_s1 <= (wa_q == hiw_q);
			if (iss_q) begin
				if (wa_q == hiw_q) begin
					iss_q <= 1'b0;
				end else begin
					wa_q <= wa_q + AW'(1);
				end
			end
		end
	end

	// Per-page masks, first-fit step and popcount over one word
	always_comb begin
		logic [XW-1:0] p;
		logic          pbusy;
		cv_c  = cv_q;
		c_c   = cand_q;
		e_c   = end_q;
		f_c   = 1'b0;
		pop_c = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			p        = XW'({addr_s1, WORD_LOG'(i)});
			rng_m[i] = (p >= lo_pg) && (p <= hi_pg);
			cnt_m[i] = (p >= bound) && (p < N_X);
			pop_c    = pop_c + (WORD_LOG + 1)'(rdata[i] & cnt_m[i]);
			pbusy    = rdata[i] || (p < bound) || (p >= N_X);
			if (!f_c) begin
				if (pbusy) begin
					cv_c = 1'b0;
				end else begin
					if (!cv_c && ((p & amask) == '0)) begin
						cv_c = 1'b1;
						c_c  = p;
						e_c  = p + cnt_x - XW'(1);
					end
					if (cv_c && (p == e_c)) begin
						f_c = 1'b1;
					end
				end
			end
		end
		dbl_c = |(rng_m & ~rdata);
	end

	assign pass_done = vld_s1 && (last_s1 || (kind_q == PASS_SCAN && f_c && !found_q));
	assign scan_upd  = vld_s1 && kind_q == PASS_SCAN && !found_q;

	// Search and check flags; the word that ends a scan is still captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q    <= 1'b0;
			found_q <= 1'b0;
			dbl_q   <= 1'b0;
			cand_q  <= '0;
			end_q   <= '0;
		end else begin
			if (cmd.go) begin
				cv_q <= 1'b0;
			end else if (scan_upd) begin
				cv_q <= cv_c;
			end
			if (cmd.go && cmd.kind == PASS_SCAN) begin
				found_q <= 1'b0;
			end else if (scan_upd) begin
				found_q <= f_c;
			end
			if (cmd.go) begin
				dbl_q <= 1'b0;
			end else if (vld_s1 && kind_q == PASS_CHECK) begin
				dbl_q <= dbl_q | dbl_c;
			end
			if (scan_upd) begin
				cand_q <= c_c;
				end_q  <= e_c;
			end
		end
	end

	// Busy page count above the reserved bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.go && cmd.kind == PASS_RECOUNT) begin
			total_q <= '0;
		end else if (vld_s1 && kind_q == PASS_RECOUNT) begin
			total_q <= total_q + CW'(pop_c);
		end else if (pass_done && kind_q == PASS_MARK) begin
			total_q <= is_free ? (total_q - CW'(cnt_x)) : (total_q + CW'(cnt_x));
		end
	end

	// Memory write side
	always_comb begin
		we    = 1'b0;
		wdata = rdata;
		case (kind_q)
			PASS_CLEAR: begin
				we    = vld_s1;
				wdata = '0;
			end
			PASS_MARK: begin
				we    = vld_s1;
				wdata = is_free ? (rdata & ~rng_m) : (rdata | rng_m);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	pba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s1),
		.wdata(wdata),
		.raddr(wa_q),
		.rdata(rdata)
	);

	assign sts.bad       = is_free ? f_bad : a_bad;
	assign sts.nomem     = !is_free && a_nomem;
	assign sts.is_free   = is_free;
	assign sts.pass_done = pass_done;
	assign sts.found     = found_q || (vld_s1 && kind_q == PASS_SCAN && f_c);
	assign sts.dbl       = dbl_q || (vld_s1 && kind_q == PASS_CHECK && dbl_c);

	// Result register, shown for one cycle
	assign sum_x = bound + XW'(total_q);

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			res_q.status          <= cmd.status;
			res_q.start_page      <= (cmd.status == ST_OK && !is_free) ? cand_q[11:0] : 12'd0;
			res_q.allocated_count <= sum_x[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.respond;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/pba_checker.sv
// Port-level checks for the page bitmap allocator, bound to the top level.
module pba_checker
	import pba_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input res_t              result,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata
);

	// A taken request makes the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after a request transfer");

	// Results never come in back-to-back cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// Start page is zero on every failed request
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.start_page == 12'd0)
		else $error("nonzero start page on failed request");

	// Reserved register reads back what was written
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == REG_RESERVED
		|=> paddr[2] != REG_RESERVED || prdata[RSV_W-1:0] == $past(pwdata[RSV_W-1:0]))
		else $error("reserved register readback mismatch");

endmodule

bind page_bitmap_allocator_top pba_checker u_chk (.*);
